[rtl/ltc_pkg.sv]
// Shared types and constants for the 3x3 local binary pattern unit.
// No dependencies; imported by ltc_line_mem and lbp_texture_code_3x3_unit.
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 11;
    localparam int MIN_DIM   = 3;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t upper;
        pix_t middle;
    } line_pair_t;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

endpackage

[rtl/ltc_line_mem.sv]
// Line buffer memory holding the two previous image rows side by side.
// Synchronous registered read; depends on ltc_pkg.
`timescale 1ns / 1ps

module ltc_line_mem #(
    parameter int DEPTH = 2048
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output ltc_pkg::line_pair_t        rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  ltc_pkg::line_pair_t        wr_data
);
    import ltc_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lbp_texture_code_3x3_unit.sv]
// Top level of the 3x3 local binary pattern unit: counters, window and output stage.
// Depends on ltc_pkg and ltc_line_mem.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_        in         tdata[7:0] grey_pixel
// m_        out        tdata[7:0] texture_code, [19:8] centre_row, [30:20] centre_col;
//                      tlast frame_last
// cfg_      in         index 0 frame_width, index 1 frame_height
//
// One pixel beat is accepted per cycle unless the output stage stalls; a code beat is
// offered once the pixel beat that completes its window has left the p1 stage.
// The line memory is read when a pixel is accepted and written back when it leaves p1.
// Reset clears the counters, window and valid flags; line contents are not cleared.
// An unaccepted output beat holds a code-producing window stage, which then holds the input.

module lbp_texture_code_3x3_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] grey_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] texture_code, [19:8] centre_row, [30:20] centre_col
    output logic        m_tlast,
    input  logic        cfg_we,
    input  ltc_pkg::cfg_idx_t cfg_index,
    input  logic [11:0] cfg_wdata
);
    import ltc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]    col_count_reg;
    logic [ROW_W-1:0] row_count_reg;

    logic                 p1_valid_reg;
    pix_t                 p1_px_reg;
    logic [CW-1:0]        p1_col_reg;
    logic                 p1_res_reg;
    logic                 p1_last_reg;
    logic [ROW_W-1:0]     p1_row_out_reg;
    logic [COL_OUT_W-1:0] p1_col_out_reg;

    pix_t win_reg [9];
    pix_t win_next [9];

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic [WW-1:0]    width_ext;
    logic [WW-1:0]    eff_width;
    logic [ROW_W:0]   eff_height;
    logic             col_wrap;
    logic             row_wrap;
    logic             s_accept;
    logic             p1_adv;
    line_pair_t       rd_data;
    line_pair_t       wr_data;
    logic [PIX_W-1:0] code;

    always_comb begin
        width_ext = WW'(frame_width_reg);
        if (width_ext < WW'(MIN_DIM)) begin
            eff_width = WW'(MIN_DIM);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        if (frame_height_reg < CFG_W'(MIN_DIM)) begin
            eff_height = (ROW_W + 1)'(MIN_DIM);
        end else begin
            eff_height = (ROW_W + 1)'(frame_height_reg);
        end
    end

    assign col_wrap = (WW'(col_count_reg) + WW'(1)) >= eff_width;
    assign row_wrap = ((ROW_W + 1)'(row_count_reg) + (ROW_W + 1)'(1)) >= eff_height;

    assign p1_adv   = p1_valid_reg && (!p1_res_reg || !m_tvalid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept) begin
            if (col_wrap) begin
                col_count_reg <= '0;
                row_count_reg <= row_wrap ? '0 : row_count_reg + 1'b1;
            end else begin
                col_count_reg <= col_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_px_reg      <= s_tdata;
            p1_col_reg     <= col_count_reg;
            p1_res_reg     <= (row_count_reg >= ROW_W'(2)) && (col_count_reg >= CW'(2));
            p1_last_reg    <= row_wrap && col_wrap;
            p1_row_out_reg <= row_count_reg - 1'b1;
            p1_col_out_reg <= COL_OUT_W'(col_count_reg - 1'b1);
        end
    end

    ltc_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_count_reg),
        .rd_data (rd_data),
        .wr_en   (p1_adv),
        .wr_addr (p1_col_reg),
        .wr_data (wr_data)
    );

    assign wr_data.upper  = rd_data.middle;
    assign wr_data.middle = p1_px_reg;

    always_comb begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_data.upper;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_data.middle;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = p1_px_reg;
        code[7] = win_next[0] > win_next[4];
        code[6] = win_next[1] > win_next[4];
        code[5] = win_next[2] > win_next[4];
        code[4] = win_next[5] > win_next[4];
        code[3] = win_next[8] > win_next[4];
        code[2] = win_next[7] > win_next[4];
        code[1] = win_next[6] > win_next[4];
        code[0] = win_next[3] > win_next[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (p1_adv) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (p1_adv && p1_res_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_res_reg) begin
            m_tdata_reg <= {1'b0, p1_col_out_reg, p1_row_out_reg, code};
            m_tlast_reg <= p1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
